// File: hw/rtl/arv_pkg.sv
// Shared widths, register codes and pipeline depths of the arrive steering block.
package arv_pkg;

  // Field and port widths
  localparam int DATA_W = 32;
  localparam int CFG_W  = 31;
  localparam int IDX_W  = 3;

  // Default fraction bits of the fixed point format
  localparam int FRAC_BITS_DEF = 16;

  // Sum of three squared 32-bit magnitudes
  localparam int RAD_W = 2 * DATA_W + 2;

  // Quotient bits of the desired-velocity and acceleration dividers
  localparam int DIV1_Q = 31;
  localparam int DIV2_Q = 32;

  // Pipeline depth from accepted start to done strobe, summed over the sections
  localparam int LATENCY = 4 + RAD_W / 2 + 1 + DIV1_Q + 4 + RAD_W / 2 + 1 + DIV2_Q + 1;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_MAX_SPEED      = 3'd0;
  localparam logic [IDX_W-1:0] REG_MAX_ACCEL      = 3'd1;
  localparam logic [IDX_W-1:0] REG_ARRIVAL_RADIUS = 3'd2;
  localparam logic [IDX_W-1:0] REG_SLOW_RADIUS    = 3'd3;
  localparam logic [IDX_W-1:0] REG_TIME_TO_TARGET = 3'd4;

endpackage

// File: hw/rtl/arv_isqrt.sv
// Pipelined integer square root, one root bit per stage.
module arv_isqrt #(
  parameter int RW = 66
) (
  input  logic            clk_i,
  input  logic [RW-1:0]   rad_i,
  output logic [RW/2-1:0] root_o
);

  localparam int NR   = RW / 2;
  localparam int REMW = NR + 2;

  logic [RW-1:0]   rad_q  [NR];
  logic [REMW-1:0] rem_q  [NR];
  logic [NR-1:0]   root_q [NR];

  for (genvar s = 0; s < NR; s++) begin : g_stage
    logic [RW-1:0]   rad_in;
    logic [REMW-1:0] rem_in;
    logic [NR-1:0]   root_in;
    logic [REMW+1:0] tmp;
    logic [REMW+1:0] trial;
    logic            ge;

    if (s == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign rad_in  = rad_q[s-1];
      assign rem_in  = rem_q[s-1];
      assign root_in = root_q[s-1];
    end

    // Bring down the next bit pair and try the trial subtrahend
    assign tmp   = {rem_in, rad_in[RW-1 -: 2]};
    assign trial = (REMW+2)'({root_in, 2'b01});
    assign ge    = (tmp >= trial);

    always_ff @(posedge clk_i) begin
      rad_q[s]  <= rad_in << 2;
      rem_q[s]  <= ge ? REMW'(tmp - trial) : REMW'(tmp);
      root_q[s] <= {root_in[NR-2:0], ge};
    end
  end

  assign root_o = root_q[NR-1];

endmodule

// File: hw/rtl/arv_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module arv_div #(
  parameter int NW = 64,
  parameter int DW = 33,
  parameter int QW = 32
) (
  input  logic          clk_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic [QW-1:0] quo_o
);

  logic [DW-1:0] rem_q [QW];
  logic [QW-1:0] lo_q  [QW];
  logic [QW-1:0] quo_q [QW];
  logic [DW-1:0] den_q [QW];

  for (genvar s = 0; s < QW; s++) begin : g_stage
    logic [DW-1:0] rem_in;
    logic [QW-1:0] lo_in;
    logic [QW-1:0] quo_in;
    logic [DW-1:0] den_in;
    logic [DW:0]   tmp;
    logic          ge;

    // The upper numerator bits start as the partial remainder (quotient fits QW bits)
    if (s == 0) begin : g_first
      assign rem_in = DW'(num_i[NW-1:QW]);
      assign lo_in  = num_i[QW-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[s-1];
      assign lo_in  = lo_q[s-1];
      assign quo_in = quo_q[s-1];
      assign den_in = den_q[s-1];
    end

    assign tmp = {rem_in, lo_in[QW-1]};
    assign ge  = (tmp >= {1'b0, den_in});

    always_ff @(posedge clk_i) begin
      rem_q[s] <= ge ? DW'(tmp - {1'b0, den_in}) : DW'(tmp);
      lo_q[s]  <= lo_in << 1;
      quo_q[s] <= {quo_in[QW-2:0], ge};
      den_q[s] <= den_in;
    end
  end

  assign quo_o = quo_q[QW-1];

endmodule

// File: hw/rtl/arv_delay.sv
// Valid and sideband delay line that runs beside a datapath pipeline.
module arv_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         v_i,
  input  logic [W-1:0] d_i,
  output logic         v_o,
  output logic [W-1:0] d_o
);

  logic [DEPTH-1:0] v_q;
  logic [W-1:0]     d_q [DEPTH];

  // Shift valid bits, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[DEPTH-2:0], v_i};
    end
  end

  // Shift the payload alongside
  for (genvar s = 0; s < DEPTH; s++) begin : g_tap
    if (s == 0) begin : g_first
      always_ff @(posedge clk_i) begin
        d_q[s] <= d_i;
      end
    end else begin : g_next
      always_ff @(posedge clk_i) begin
        d_q[s] <= d_q[s-1];
      end
    end
  end

  assign v_o = v_q[DEPTH-1];
  assign d_o = d_q[DEPTH-1];

endmodule

// File: hw/rtl/arrive_steering.sv
// Arrive steering top level: offset, magnitude, desired velocity, acceleration and clamp.
//
// One agent enters per clock: an item is taken whenever start_i is high
// (busy_o stays low) and its result appears as a one-cycle done_o strobe
// with accel_*_o and steering_active_o. The receiver cannot hold results
// off, and none are needed: every stage advances each cycle. The pipeline
// is made of two 33-stage square root pipelines (offset length and error
// length) and two dividers that produce one quotient bit per stage (31 bits
// for the desired velocity, 32 for the acceleration), plus eleven stages of
// glue for offsets, squares, sums, limit tests and the final clamp. Write the
// configuration registers only while no item is in flight.
module arrive_steering
  import arv_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic signed [DATA_W-1:0] target_x_i,
  input  logic signed [DATA_W-1:0] target_y_i,
  input  logic signed [DATA_W-1:0] target_z_i,
  input  logic signed [DATA_W-1:0] pos_x_i,
  input  logic signed [DATA_W-1:0] pos_y_i,
  input  logic signed [DATA_W-1:0] pos_z_i,
  input  logic signed [DATA_W-1:0] vel_x_i,
  input  logic signed [DATA_W-1:0] vel_y_i,
  input  logic signed [DATA_W-1:0] vel_z_i,
  input  logic                     cfg_we_i,
  input  logic [IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]         cfg_wdata_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] accel_x_o,
  output logic signed [DATA_W-1:0] accel_y_o,
  output logic signed [DATA_W-1:0] accel_z_o,
  output logic                     steering_active_o
);

  localparam int NR  = RAD_W / 2;
  localparam int PW  = 2 * DATA_W;
  localparam logic [CFG_W-1:0] TTT_DEF = CFG_W'(((1 << FRAC_BITS) + 5) / 10);
  localparam logic [CFG_W-1:0] MAX_SPEED_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] MAX_ACCEL_RST   = 31'd65536;
  localparam logic [CFG_W-1:0] ARRIVAL_RST     = 31'd65536;
  localparam logic [CFG_W-1:0] SLOW_RST        = 31'd327680;
  localparam logic [CFG_W-1:0] TTT_RST         = 31'd6554;
  localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef struct packed {
    logic [2:0][DATA_W-1:0] mag;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] vel;
  } ofs_side_t;

  typedef struct packed {
    logic                   arrived;
    logic                   zdv;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] vel;
  } des_side_t;

  typedef struct packed {
    logic                   arrived;
    logic [2:0]             neg;
    logic [2:0][DATA_W-1:0] mag;
  } err_side_t;

  typedef struct packed {
    logic       arrived;
    logic [2:0] neg;
    logic [2:0] ovf;
  } out_side_t;

  // ---------------------------------------------------------------- config
  logic [CFG_W-1:0]   max_speed_q, max_accel_q, arrival_radius_q, slow_radius_q, ttt_q;
  logic [CFG_W-1:0]   ttt_eff;
  logic [2*CFG_W-1:0] ma_tt_q;

  // Write the addressed register; unknown indexes drop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_speed_q      <= MAX_SPEED_RST;
      max_accel_q      <= MAX_ACCEL_RST;
      arrival_radius_q <= ARRIVAL_RST;
      slow_radius_q    <= SLOW_RST;
      ttt_q            <= TTT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAX_SPEED:      max_speed_q      <= cfg_wdata_i;
        REG_MAX_ACCEL:      max_accel_q      <= cfg_wdata_i;
        REG_ARRIVAL_RADIUS: arrival_radius_q <= cfg_wdata_i;
        REG_SLOW_RADIUS:    slow_radius_q    <= cfg_wdata_i;
        REG_TIME_TO_TARGET: ttt_q            <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Replace a zero time to target by 0.1 and hold the acceleration limit product
  assign ttt_eff = (ttt_q == '0) ? TTT_DEF : ttt_q;

  always_ff @(posedge clk_i) begin
    ma_tt_q <= max_accel_q * ttt_eff;
  end

  assign busy_o = 1'b0;

  // ---------------------------------------------------------------- valids
  logic p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q, p6_v_q, p7_v_q, p8_v_q, p9_v_q;
  logic p10_v_q, done_q;
  logic s1_v, s2_v, s3_v, s4_v;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q  <= 1'b0;
      p2_v_q  <= 1'b0;
      p3_v_q  <= 1'b0;
      p4_v_q  <= 1'b0;
      p5_v_q  <= 1'b0;
      p6_v_q  <= 1'b0;
      p7_v_q  <= 1'b0;
      p8_v_q  <= 1'b0;
      p9_v_q  <= 1'b0;
      p10_v_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      p1_v_q  <= start_i && !busy_o;
      p2_v_q  <= p1_v_q;
      p3_v_q  <= p2_v_q;
      p4_v_q  <= p3_v_q;
      p5_v_q  <= s1_v;
      p6_v_q  <= s2_v;
      p7_v_q  <= p6_v_q;
      p8_v_q  <= p7_v_q;
      p9_v_q  <= p8_v_q;
      p10_v_q <= s3_v;
      done_q  <= s4_v;
    end
  end

  // ---------------------------------------------------------------- offset
  logic [2:0][DATA_W-1:0] tgt, pos, vel_in;

  assign tgt    = {target_z_i, target_y_i, target_x_i};
  assign pos    = {pos_z_i, pos_y_i, pos_x_i};
  assign vel_in = {vel_z_i, vel_y_i, vel_x_i};

  logic [2:0][DATA_W:0]   p1_ofs_q;
  logic [2:0][DATA_W-1:0] p1_vel_q;

  // Take the offset to the target
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p1_ofs_q[k] <= {tgt[k][DATA_W-1], tgt[k]} - {pos[k][DATA_W-1], pos[k]};
    end
    p1_vel_q <= vel_in;
  end

  // Split into sign and magnitude
  ofs_side_t p2_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p2_side_q.neg[k] <= p1_ofs_q[k][DATA_W];
      p2_side_q.mag[k] <= p1_ofs_q[k][DATA_W] ? DATA_W'((DATA_W+1)'(0) - p1_ofs_q[k])
                                              : p1_ofs_q[k][DATA_W-1:0];
    end
    p2_side_q.vel <= p1_vel_q;
  end

  // Square each component
  logic [2:0][PW-1:0] p3_sq_q;
  ofs_side_t          p3_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p3_sq_q[k] <= p2_side_q.mag[k] * p2_side_q.mag[k];
    end
    p3_side_q <= p2_side_q;
  end

  // Sum the squares
  logic [RAD_W-1:0] p4_sum_q;
  ofs_side_t        p4_side_q;

  always_ff @(posedge clk_i) begin
    p4_sum_q  <= RAD_W'(p3_sq_q[0]) + RAD_W'(p3_sq_q[1]) + RAD_W'(p3_sq_q[2]);
    p4_side_q <= p3_side_q;
  end

  // Offset length
  logic [NR-1:0] mag_w;
  ofs_side_t     s1_side;

  arv_isqrt #(.RW(RAD_W)) u_sqrt_ofs (
    .clk_i  (clk_i),
    .rad_i  (p4_sum_q),
    .root_o (mag_w)
  );

  arv_delay #(.W($bits(ofs_side_t)), .DEPTH(NR)) u_dly_ofs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (p4_v_q),
    .d_i    (p4_side_q),
    .v_o    (s1_v),
    .d_o    (s1_side)
  );

  // ---------------------------------------------------------------- desired velocity
  logic          arrived_w, slow_w;
  logic [NR-1:0] den1_w;

  assign arrived_w = (mag_w < NR'(arrival_radius_q));
  assign slow_w    = (mag_w < NR'(slow_radius_q));
  assign den1_w    = slow_w ? NR'(slow_radius_q) : mag_w;

  logic [2:0][PW-1:0] p5_num_q;
  logic [NR-1:0]      p5_den_q;
  des_side_t          p5_side_q;

  // Scale offset by max speed and pick the divisor
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p5_num_q[k] <= s1_side.mag[k] * max_speed_q;
    end
    p5_den_q          <= den1_w;
    p5_side_q.arrived <= arrived_w;
    p5_side_q.zdv     <= (den1_w == '0);
    p5_side_q.neg     <= s1_side.neg;
    p5_side_q.vel     <= s1_side.vel;
  end

  logic [2:0][DIV1_Q-1:0] q1_w;
  des_side_t              s2_side;

  for (genvar k = 0; k < 3; k++) begin : g_div_des
    arv_div #(.NW(PW), .DW(NR), .QW(DIV1_Q)) u_div (
      .clk_i (clk_i),
      .num_i (p5_num_q[k]),
      .den_i (p5_den_q),
      .quo_o (q1_w[k])
    );
  end

  arv_delay #(.W($bits(des_side_t)), .DEPTH(DIV1_Q)) u_dly_des (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (p5_v_q),
    .d_i    (p5_side_q),
    .v_o    (s2_v),
    .d_o    (s2_side)
  );

  // ---------------------------------------------------------------- velocity error
  logic [2:0][DATA_W-1:0] des_w;

  // Restore the sign; a zero divisor means no direction
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s2_side.zdv) begin
        des_w[k] = '0;
      end else if (s2_side.neg[k]) begin
        des_w[k] = DATA_W'(0) - DATA_W'(q1_w[k]);
      end else begin
        des_w[k] = DATA_W'(q1_w[k]);
      end
    end
  end

  logic [2:0][DATA_W:0] p6_err_q;
  logic                 p6_arr_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p6_err_q[k] <= {des_w[k][DATA_W-1], des_w[k]}
                   - {s2_side.vel[k][DATA_W-1], s2_side.vel[k]};
    end
    p6_arr_q <= s2_side.arrived;
  end

  // Split error into sign and magnitude
  err_side_t p7_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p7_side_q.neg[k] <= p6_err_q[k][DATA_W];
      p7_side_q.mag[k] <= p6_err_q[k][DATA_W] ? DATA_W'((DATA_W+1)'(0) - p6_err_q[k])
                                              : p6_err_q[k][DATA_W-1:0];
    end
    p7_side_q.arrived <= p6_arr_q;
  end

  // Square the error components
  logic [2:0][PW-1:0] p8_sq_q;
  err_side_t          p8_side_q;

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      p8_sq_q[k] <= p7_side_q.mag[k] * p7_side_q.mag[k];
    end
    p8_side_q <= p7_side_q;
  end

  logic [RAD_W-1:0] p9_sum_q;
  err_side_t        p9_side_q;

  always_ff @(posedge clk_i) begin
    p9_sum_q  <= RAD_W'(p8_sq_q[0]) + RAD_W'(p8_sq_q[1]) + RAD_W'(p8_sq_q[2]);
    p9_side_q <= p8_side_q;
  end

  // Error length
  logic [NR-1:0] m_w;
  err_side_t     s3_side;

  arv_isqrt #(.RW(RAD_W)) u_sqrt_err (
    .clk_i  (clk_i),
    .rad_i  (p9_sum_q),
    .root_o (m_w)
  );

  arv_delay #(.W($bits(err_side_t)), .DEPTH(NR)) u_dly_err (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (p9_v_q),
    .d_i    (p9_side_q),
    .v_o    (s3_v),
    .d_o    (s3_side)
  );

  // ---------------------------------------------------------------- acceleration
  logic               cap_w;
  logic [2:0][PW-1:0] prod_w, shl_w, num2_w;
  logic [2:0]         ovf_w;

  assign cap_w = ((PW'(m_w) << FRAC_BITS) > PW'(ma_tt_q));

  // Capped: error times max accel over its length; else error over time to target
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      prod_w[k] = s3_side.mag[k] * max_accel_q;
      shl_w[k]  = PW'(s3_side.mag[k]) << FRAC_BITS;
      ovf_w[k]  = !cap_w && (shl_w[k][PW-1:DATA_W] >= DATA_W'(ttt_eff));
      if (cap_w) begin
        num2_w[k] = prod_w[k];
      end else if (ovf_w[k]) begin
        num2_w[k] = '0;
      end else begin
        num2_w[k] = shl_w[k];
      end
    end
  end

  logic [2:0][PW-1:0] p10_num_q;
  logic [NR-1:0]      p10_den_q;
  out_side_t          p10_side_q;

  always_ff @(posedge clk_i) begin
    p10_num_q          <= num2_w;
    p10_den_q          <= cap_w ? m_w : NR'(ttt_eff);
    p10_side_q.arrived <= s3_side.arrived;
    p10_side_q.neg     <= s3_side.neg;
    p10_side_q.ovf     <= ovf_w;
  end

  logic [2:0][DIV2_Q-1:0] q2_w;
  out_side_t              s4_side;

  for (genvar k = 0; k < 3; k++) begin : g_div_acc
    arv_div #(.NW(PW), .DW(NR), .QW(DIV2_Q)) u_div (
      .clk_i (clk_i),
      .num_i (p10_num_q[k]),
      .den_i (p10_den_q),
      .quo_o (q2_w[k])
    );
  end

  arv_delay #(.W($bits(out_side_t)), .DEPTH(DIV2_Q)) u_dly_acc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .v_i    (p10_v_q),
    .d_i    (p10_side_q),
    .v_o    (s4_v),
    .d_o    (s4_side)
  );

  // ---------------------------------------------------------------- clamp and output
  logic [2:0][DATA_W-1:0] acc_w;
  logic [2:0][DATA_W-1:0] acc_q;
  logic                   act_q;

  // Apply sign and saturate; arrived gives zero
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s4_side.arrived) begin
        acc_w[k] = '0;
      end else if (s4_side.ovf[k]) begin
        acc_w[k] = s4_side.neg[k] ? SAT_MIN : SAT_MAX;
      end else if (s4_side.neg[k]) begin
        acc_w[k] = (DATA_W'(q2_w[k]) > SAT_MIN) ? SAT_MIN : DATA_W'(0) - DATA_W'(q2_w[k]);
      end else begin
        acc_w[k] = q2_w[k][DIV2_Q-1] ? SAT_MAX : DATA_W'(q2_w[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_w;
    act_q <= !s4_side.arrived;
  end

  assign done_o            = done_q;
  assign accel_x_o         = acc_q[0];
  assign accel_y_o         = acc_q[1];
  assign accel_z_o         = acc_q[2];
  assign steering_active_o = act_q;

endmodule

// File: hw/rtl/arv_checker.sv
// Port-level checks for the arrive steering block, bound to its top level.
module arv_checker
  import arv_pkg::*;
(
  input logic                     clk_i,
  input logic                     rst_ni,
  input logic                     start_i,
  input logic                     busy_o,
  input logic signed [DATA_W-1:0] target_x_i,
  input logic signed [DATA_W-1:0] target_y_i,
  input logic signed [DATA_W-1:0] target_z_i,
  input logic signed [DATA_W-1:0] pos_x_i,
  input logic signed [DATA_W-1:0] pos_y_i,
  input logic signed [DATA_W-1:0] pos_z_i,
  input logic signed [DATA_W-1:0] vel_x_i,
  input logic signed [DATA_W-1:0] vel_y_i,
  input logic signed [DATA_W-1:0] vel_z_i,
  input logic                     cfg_we_i,
  input logic [IDX_W-1:0]         cfg_idx_i,
  input logic [CFG_W-1:0]         cfg_wdata_i,
  input logic                     done_o,
  input logic signed [DATA_W-1:0] accel_x_o,
  input logic signed [DATA_W-1:0] accel_y_o,
  input logic signed [DATA_W-1:0] accel_z_o,
  input logic                     steering_active_o
);

  // Every accepted transfer yields a result after the fixed latency
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |-> ##LATENCY done_o)
    else $error("accepted item produced no result");

  // No result without a transfer the fixed latency earlier
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o, LATENCY))
    else $error("result without matching input");

  // Arrived agents get zero acceleration
  a_arrived_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !steering_active_o |->
      accel_x_o == '0 && accel_y_o == '0 && accel_z_o == '0)
    else $error("nonzero acceleration after arrival");

endmodule

bind arrive_steering arv_checker u_arv_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .start_i           (start_i),
  .busy_o            (busy_o),
  .target_x_i        (target_x_i),
  .target_y_i        (target_y_i),
  .target_z_i        (target_z_i),
  .pos_x_i           (pos_x_i),
  .pos_y_i           (pos_y_i),
  .pos_z_i           (pos_z_i),
  .vel_x_i           (vel_x_i),
  .vel_y_i           (vel_y_i),
  .vel_z_i           (vel_z_i),
  .cfg_we_i          (cfg_we_i),
  .cfg_idx_i         (cfg_idx_i),
  .cfg_wdata_i       (cfg_wdata_i),
  .done_o            (done_o),
  .accel_x_o         (accel_x_o),
  .accel_y_o         (accel_y_o),
  .accel_z_o         (accel_z_o),
  .steering_active_o (steering_active_o)
);
